### design/hec_pkg.sv
package hec_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int MAX_CODE_BITS = 63;
    localparam int CFG_W         = 6;
    localparam int POS_W         = 6;
    localparam int MAX_PARITY    = 6;

    typedef enum logic
    {
        FUNC_ENCODE = 1'b0,
        FUNC_CHECK  = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [MAX_CODE_BITS-1:0] code_out;
        logic [POS_W-1:0]         error_position;
        logic                     error_found;
        logic                     beyond_length;
    } result_t;

    // Code length n = m + r for a raw data_bits value (clamped to 1..57).
    function automatic logic [POS_W-1:0] code_len(input logic [CFG_W-1:0] bits);
        logic [CFG_W-1:0] m;
        logic [3:0]       r;
        logic [7:0]       lim;
        m = bits;
        if (m == '0)
        begin
            m = CFG_W'(1);
        end
        if (m > CFG_W'(MAX_DATA_BITS))
        begin
            m = CFG_W'(MAX_DATA_BITS);
        end
        r = '0;
        for (int i = 0; i < 7; i++)
        begin
            lim = 8'(m) + 8'(r) + 8'd1;
            if ((8'd1 << r) < lim)
            begin
                r = r + 4'd1;
            end
        end
        return POS_W'(7'(m) + 7'(r));
    endfunction

    // Bits 0..n-1 set.
    function automatic logic [MAX_CODE_BITS-1:0] len_mask(input logic [POS_W-1:0] n);
        logic [MAX_CODE_BITS-1:0] mask;
        for (int k = 0; k < MAX_CODE_BITS; k++)
        begin
            mask[k] = (k < int'(n));
        end
        return mask;
    endfunction

    // Data bits go in order to the positions that are not powers of two.
    function automatic logic [MAX_CODE_BITS-1:0] scatter(input logic [MAX_DATA_BITS-1:0] d);
        logic [MAX_CODE_BITS-1:0] w;
        int                       j;
        w = '0;
        j = 0;
        for (int k = 1; k <= MAX_CODE_BITS; k++)
        begin
            if ((k & (k - 1)) != 0)
            begin
                w[k-1] = d[j];
                j++;
            end
        end
        return w;
    endfunction

    // Syndrome bit i = parity of all positions whose index has bit i set.
    function automatic logic [POS_W-1:0] syndrome(input logic [MAX_CODE_BITS-1:0] w);
        logic [POS_W-1:0] s;
        s = '0;
        for (int k = 1; k <= MAX_CODE_BITS; k++)
        begin
            for (int i = 0; i < POS_W; i++)
            begin
                if (((k >> i) & 1) != 0)
                begin
                    s[i] = s[i] ^ w[k-1];
                end
            end
        end
        return s;
    endfunction

endpackage

### design/hec_if.sv
interface hec_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [hec_pkg::MAX_DATA_BITS-1:0]  data_word;
    logic [hec_pkg::MAX_CODE_BITS-1:0]  code_word;

    modport source (output valid, func, data_word, code_word, input ready);
    modport sink   (input valid, func, data_word, code_word, output ready);
endinterface

interface hec_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [hec_pkg::MAX_CODE_BITS-1:0]  code_out;
    logic [hec_pkg::POS_W-1:0]          error_position;
    logic                               error_found;
    logic                               beyond_length;

    modport source (output valid, code_out, error_position, error_found, beyond_length,
                    input ready);
    modport sink   (input valid, code_out, error_position, error_found, beyond_length,
                    output ready);
endinterface

### design/hamming_encode_correct_unit.sv
// Hamming single-error-correcting encoder / checker.
//
// cmd channel: valid/ready with func, data_word, code_word. func = encode
//   builds a code word from data_word; func = check recomputes the
//   syndrome of code_word, corrects one bit (unless the syndrome points past the code length) and reports the syndrome.
// rsp channel: valid/ready with code_out, error_position, error_found,
//   beyond_length. Exactly one result per cmd transfer, in order.
// cfg: cfg_wr_en / cfg_wr_data set the data width m (1..57, out-of-range
//   values clamp). The code length n and its mask are computed at write
//   time; write only while the block is idle.
// Path: a cmd word passes the input register, the XOR trees and the result
//   register before rsp valid rises. Throughput: one transfer per cycle
//   while rsp.ready stays high; the encode and check XOR trees sit side
//   by side between the two registers.
// Stall: when rsp is held off, the result register keeps its word and the
//   input register can still take one more transfer; cmd.ready drops
//   only while both registers are full and rsp.ready is low.
// Reset: both stages empty, m = 4 (n = 7).
module hamming_encode_correct_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [hec_pkg::CFG_W-1:0] cfg_wr_data,
    hec_cmd_if.sink                   cmd,
    hec_rsp_if.source                 rsp
);

    // Configuration: only the derived code length and mask are kept.
    logic [hec_pkg::POS_W-1:0]         n_reg;
    logic [hec_pkg::MAX_CODE_BITS-1:0] mask_reg;
    logic [hec_pkg::POS_W-1:0]         n_next;

    // Input stage.
    logic                              s1_valid_reg;
    logic                              s1_func_reg;
    logic [hec_pkg::MAX_DATA_BITS-1:0] s1_data_reg;
    logic [hec_pkg::MAX_CODE_BITS-1:0] s1_code_reg;

    // Result stage.
    logic                              rsp_valid_reg;
    hec_pkg::result_t                  rsp_reg;
    hec_pkg::result_t                  result_next;

    logic                              s1_advance;
    logic                              cmd_take;

    assign n_next = hec_pkg::code_len(cfg_wr_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= hec_pkg::POS_W'(7);
            mask_reg <= hec_pkg::len_mask(hec_pkg::POS_W'(7));
        end
        else if (cfg_wr_en)
        begin
            n_reg    <= n_next;
            mask_reg <= hec_pkg::len_mask(n_next);
        end
    end

    // Result register frees when empty or when its word transfers.
    assign s1_advance = !rsp_valid_reg || rsp.ready;
    assign cmd_take   = cmd.valid && cmd.ready;
    assign cmd.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_func_reg <= cmd.func;
            s1_data_reg <= cmd.data_word;
            s1_code_reg <= cmd.code_word;
        end
    end

    hec_core u_core
    (
        .func      (s1_func_reg),
        .data_word (s1_data_reg),
        .code_word (s1_code_reg),
        .code_len  (n_reg),
        .code_mask (mask_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            rsp_reg <= result_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.code_out       = rsp_reg.code_out;
    assign rsp.error_position = rsp_reg.error_position;
    assign rsp.error_found    = rsp_reg.error_found;
    assign rsp.beyond_length  = rsp_reg.beyond_length;

    // Flag consistency against the syndrome and the configured length.
    a_found_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.error_found == (rsp_reg.error_position != '0)))
        else $error("error_found disagrees with error_position");

    a_beyond_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.beyond_length == (rsp_reg.error_position > n_reg)))
        else $error("beyond_length disagrees with code length");

    a_no_bits_past_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.code_out & ~mask_reg) == '0))
        else $error("code_out has bits past the code length");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("cmd accepted while both stages are full");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> rsp_valid_reg)
        else $error("input stage word lost on advance");

endmodule

### design/hec_core.sv
module hec_core
(
    input  logic                              func,
    input  logic [hec_pkg::MAX_DATA_BITS-1:0] data_word,
    input  logic [hec_pkg::MAX_CODE_BITS-1:0] code_word,
    input  logic [hec_pkg::POS_W-1:0]         code_len,
    input  logic [hec_pkg::MAX_CODE_BITS-1:0] code_mask,
    output hec_pkg::result_t                  result
);

    logic [hec_pkg::MAX_CODE_BITS-1:0] placed;
    logic [hec_pkg::POS_W-1:0]         enc_par;
    logic [hec_pkg::MAX_CODE_BITS-1:0] enc_word;
    logic [hec_pkg::MAX_CODE_BITS-1:0] rx_word;
    logic [hec_pkg::POS_W-1:0]         synd;
    logic                              beyond;
    logic [hec_pkg::MAX_CODE_BITS-1:0] flip;

    // Encode: parity slots are still zero, so the syndrome is the parity.
    always_comb
    begin
        placed   = hec_pkg::scatter(data_word) & code_mask;
        enc_par  = hec_pkg::syndrome(placed);
        enc_word = placed;
        for (int i = 0; i < hec_pkg::MAX_PARITY; i++)
        begin
            enc_word[(1 << i) - 1] = enc_par[i];
        end
    end

    // Check: flip the addressed position unless it lies past the code.
    always_comb
    begin
        rx_word = code_word & code_mask;
        synd    = hec_pkg::syndrome(rx_word);
        beyond  = (synd > code_len);
        flip    = '0;
        if (synd != '0 && !beyond)
        begin
            flip = hec_pkg::MAX_CODE_BITS'(1) << (synd - hec_pkg::POS_W'(1));
        end
    end

    always_comb
    begin
        if (func == hec_pkg::FUNC_CHECK)
        begin
            result.code_out       = rx_word ^ flip;
            result.error_position = synd;
            result.error_found    = (synd != '0);
            result.beyond_length  = beyond;
        end
        else
        begin
            result.code_out       = enc_word;
            result.error_position = '0;
            result.error_found    = 1'b0;
            result.beyond_length  = 1'b0;
        end
    end

endmodule
